>>> sv/itrfw_pkg.sv
// Shared types, codes and helpers for the indexed-to-RGB565 frame writer.
// Used by itrfw_addr_gen and indexed_to_rgb565_frame_writer.
package itrfw_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_PALETTE = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_PIXELS  = 2'd2;

  // Output mode codes
  localparam logic [1:0] MODE_PACKED  = 2'd0;
  localparam logic [1:0] MODE_DOUBLED = 2'd1;
  localparam logic [1:0] MODE_SKIP    = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WORDS  = 1'd1;
  localparam int unsigned CFG_DATA_W = 11;

  // Reset and limits of the line length
  localparam logic [10:0] LINE_WORDS_RESET = 11'd320;
  localparam logic [10:0] LINE_WORDS_MAX   = 11'd1024;

  localparam int unsigned WORD_ADDR_W = 21;
  localparam int unsigned COLOUR_W    = 16;

  typedef struct packed {
    logic [1:0]             operation;
    logic [7:0]             entry_index;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [WORD_ADDR_W-1:0] start_address;
    logic [7:0]             pixel_a;
    logic [7:0]             pixel_b;
    logic                   final_pair;
  } in_item_t;

  typedef struct packed {
    logic [WORD_ADDR_W-1:0] word_address;
    logic [31:0]            word_data;
    logic                   run_last;
    logic                   update_done;
  } out_item_t;

  // Address generator controls for one accepted transaction
  typedef struct packed {
    logic start;
    logic pair;
    logic doubled;
    logic skip;
  } addr_ctl_t;

  // Pack 8-bit components into one RGB565 colour
  function automatic logic [COLOUR_W-1:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> sv/itrfw_clut.sv
// Colour lookup table: one write port and two registered read ports.
// Stand-alone; no package dependency.
module itrfw_clut #(
  parameter int unsigned ENTRIES = 256,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_a_i,
  input  logic [IDX_W-1:0] raddr_b_i,
  output logic [15:0]      rdata_a_o,
  output logic [15:0]      rdata_b_o
);

  logic [15:0] mem_q [ENTRIES];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read both pixels; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> sv/itrfw_addr_gen.sv
// Word address counter and line position tracking for the frame writer.
// Depends on itrfw_pkg for the control struct and line-length constants.
module itrfw_addr_gen #(
  parameter int unsigned ADDRESS_BITS = 21
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itrfw_pkg::addr_ctl_t              ctl_i,
  input  logic [itrfw_pkg::WORD_ADDR_W-1:0] start_address_i,
  input  logic [10:0]                       line_words_i,
  output logic [itrfw_pkg::WORD_ADDR_W-1:0] addr0_o,
  output logic [itrfw_pkg::WORD_ADDR_W-1:0] addr1_o
);

  localparam int unsigned XW = (ADDRESS_BITS > itrfw_pkg::WORD_ADDR_W) ?
                               ADDRESS_BITS : itrfw_pkg::WORD_ADDR_W;
  localparam int unsigned SW = ADDRESS_BITS + 2;

  logic [ADDRESS_BITS-1:0] ctr_q, ctr_d;
  logic [9:0]              pos_q, pos_d;
  logic [ADDRESS_BITS-1:0] ctr_inc1, ctr_inc2;
  logic [SW-1:0]           jump_sum;
  logic [10:0]             len;
  logic [10:0]             pos_next;
  logic [XW-1:0]           start_x, addr0_x, addr1_x;

  // Clamp the line length to 1..1024
  always_comb begin
    len = line_words_i;
    if (line_words_i == 11'd0) begin
      len = 11'd1;
    end else if (line_words_i > itrfw_pkg::LINE_WORDS_MAX) begin
      len = itrfw_pkg::LINE_WORDS_MAX;
    end
  end

  assign ctr_inc1 = ctr_q + ADDRESS_BITS'(1);
  assign ctr_inc2 = ctr_q + ADDRESS_BITS'(2);
  assign jump_sum = SW'(ctr_q) + SW'(1) + SW'(len);
  assign pos_next = {1'b0, pos_q} + 11'd1;
  assign start_x  = XW'(start_address_i);

  // Advance the counter per transaction
  always_comb begin
    ctr_d = ctr_q;
    pos_d = pos_q;
    if (ctl_i.start) begin
      ctr_d = start_x[ADDRESS_BITS-1:0];
      pos_d = 10'd0;
    end else if (ctl_i.pair) begin
      if (ctl_i.doubled) begin
        ctr_d = ctr_inc2;
      end else if (ctl_i.skip) begin
        if (pos_next >= len) begin
          ctr_d = jump_sum[ADDRESS_BITS-1:0];
          pos_d = 10'd0;
        end else begin
          ctr_d = ctr_inc1;
          pos_d = pos_next[9:0];
        end
      end else begin
        ctr_d = ctr_inc1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      pos_q <= '0;
    end else begin
      ctr_q <= ctr_d;
      pos_q <= pos_d;
    end
  end

  // Present addresses of the first and second word of a pair
  assign addr0_x = XW'(ctr_q);
  assign addr1_x = XW'(ctr_inc1);
  assign addr0_o = addr0_x[itrfw_pkg::WORD_ADDR_W-1:0];
  assign addr1_o = addr1_x[itrfw_pkg::WORD_ADDR_W-1:0];

  // A start always rewinds the line position
  a_start_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> (pos_q == 10'd0))
    else $error("line position not cleared by start");

  // Packed mode leaves the line position alone
  a_packed_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.pair && !ctl_i.start && !ctl_i.doubled && !ctl_i.skip) |=> $stable(pos_q))
    else $error("line position moved in packed mode");

  // Doubled mode steps the counter by two
  a_doubled_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.pair && !ctl_i.start && ctl_i.doubled) |=> (ctr_q == $past(ctr_inc2)))
    else $error("doubled mode counter step wrong");

endmodule

>>> sv/indexed_to_rgb565_frame_writer.sv
// An accepted pixel pair passes the lookup stage (table read) and then the output register.
// Throughput: one transaction per cycle while the output is not stalled; a doubled pair holds its stage for two words.
// Palette writes and starts give no output; the table has one write port.
// Reset clears counters, mode and valid flags; line_words resets to 320.
// Colour table contents are undefined until written; there is no clearing pass.
// Top level; depends on itrfw_pkg, itrfw_clut and itrfw_addr_gen.
module indexed_to_rgb565_frame_writer #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned ADDRESS_BITS  = 21
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  itrfw_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output itrfw_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [itrfw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [itrfw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [8:0] ENTRIES_9 = 9'(TABLE_ENTRIES);

  // Configuration registers
  logic [1:0]  mode_q;
  logic [10:0] line_words_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= itrfw_pkg::MODE_PACKED;
      line_words_q <= itrfw_pkg::LINE_WORDS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        itrfw_pkg::CFG_OUTPUT_MODE: mode_q       <= cfg_data_i[1:0];
        itrfw_pkg::CFG_LINE_WORDS:  line_words_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic mode_doubled, mode_skip;
  assign mode_doubled = (mode_q == itrfw_pkg::MODE_DOUBLED);
  assign mode_skip    = (mode_q == itrfw_pkg::MODE_SKIP);

  // Handshake and decode
  logic in_accept, acc_palette, acc_start, acc_pair;
  logic s1_valid_q, s1_doubled_q, s1_phase_q, s1_fin_q, s1_a_ok_q, s1_b_ok_q;
  logic [itrfw_pkg::WORD_ADDR_W-1:0] s1_addr0_q, s1_addr1_q;
  logic out_free, out_load, s1_leave;

  assign out_free   = !out_valid_o || out_ready_i;
  assign out_load   = s1_valid_q && out_free;
  assign s1_leave   = out_load && (!s1_doubled_q || s1_phase_q);
  assign in_ready_o = !s1_valid_q || s1_leave;
  assign in_accept  = in_valid_i && in_ready_o;

  assign acc_palette = in_accept && (in_data_i.operation == itrfw_pkg::OP_PALETTE);
  assign acc_start   = in_accept && (in_data_i.operation == itrfw_pkg::OP_START);
  assign acc_pair    = in_accept && (in_data_i.operation == itrfw_pkg::OP_PIXELS);

  // Colour table
  logic pal_ok, a_ok, b_ok;
  logic [15:0] rd_a, rd_b;

  assign pal_ok = ({1'b0, in_data_i.entry_index} < ENTRIES_9);
  assign a_ok   = ({1'b0, in_data_i.pixel_a} < ENTRIES_9);
  assign b_ok   = ({1'b0, in_data_i.pixel_b} < ENTRIES_9);

  itrfw_clut #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_clut (
    .clk_i     (clk_i),
    .we_i      (acc_palette && pal_ok),
    .waddr_i   (in_data_i.entry_index[IDX_W-1:0]),
    .wdata_i   (itrfw_pkg::rgb565(in_data_i.red, in_data_i.green, in_data_i.blue)),
    .re_i      (acc_pair),
    .raddr_a_i (in_data_i.pixel_a[IDX_W-1:0]),
    .raddr_b_i (in_data_i.pixel_b[IDX_W-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Address generation
  itrfw_pkg::addr_ctl_t addr_ctl;
  logic [itrfw_pkg::WORD_ADDR_W-1:0] addr0, addr1;

  assign addr_ctl.start   = acc_start;
  assign addr_ctl.pair    = acc_pair;
  assign addr_ctl.doubled = mode_doubled;
  assign addr_ctl.skip    = mode_skip;

  itrfw_addr_gen #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_addr_gen (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (addr_ctl),
    .start_address_i (in_data_i.start_address),
    .line_words_i    (line_words_q),
    .addr0_o         (addr0),
    .addr1_o         (addr1)
  );

  // Lookup stage: hold the pair while the table read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= 1'b0;
    end else begin
      if (acc_pair) begin
        s1_valid_q <= 1'b1;
      end else if (s1_leave) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_leave) begin
        s1_phase_q <= 1'b0;
      end else if (out_load && s1_doubled_q) begin
        s1_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_pair) begin
      s1_doubled_q <= mode_doubled;
      s1_fin_q     <= in_data_i.final_pair;
      s1_a_ok_q    <= a_ok;
      s1_b_ok_q    <= b_ok;
      s1_addr0_q   <= addr0;
      s1_addr1_q   <= addr1;
    end
  end

  // Form the output word
  logic [15:0] col_a, col_b;
  itrfw_pkg::out_item_t word_d;

  assign col_a = s1_a_ok_q ? rd_a : 16'd0;
  assign col_b = s1_b_ok_q ? rd_b : 16'd0;

  always_comb begin
    word_d.word_address = s1_addr0_q;
    word_d.word_data    = {col_b, col_a};
    word_d.run_last     = 1'b1;
    word_d.update_done  = s1_fin_q;
    if (s1_doubled_q) begin
      if (s1_phase_q) begin
        word_d.word_address = s1_addr1_q;
        word_d.word_data    = {col_b, col_b};
      end else begin
        word_d.word_data    = {col_a, col_a};
        word_d.run_last     = 1'b0;
        word_d.update_done  = 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_o <= word_d;
    end
  end

  // Second-word phase only exists for a held doubled pair
  a_phase_doubled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_phase_q |-> (s1_valid_q && s1_doubled_q))
    else $error("second-word phase without a doubled pair");

  // An accepted pair always occupies the lookup stage next cycle
  a_pair_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pair |=> s1_valid_q)
    else $error("accepted pair lost");

  // Update done only on the last word of a transaction
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.update_done || out_data_o.run_last))
    else $error("update_done on a non-final word");

  // A doubled first word is always followed by its second word from the stage
  a_doubled_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && s1_doubled_q && !s1_phase_q) |=> (s1_valid_q && s1_phase_q))
    else $error("second word of doubled pair dropped");

endmodule
